FILE: src/assert_macros.svh
// Assertion macros for the checker of the drain rate monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BDRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drain monitor check failed");

// Next-cycle implication, switched off while reset is asserted.
`define BDRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("drain monitor check failed");

`endif

FILE: src/bdrm_pkg.sv
// Shared types, constants and controller/datapath interface of the drain rate monitor.
package bdrm_pkg;

	localparam int DEF_WINDOW_DEPTH = 10;
	localparam int DEF_CHANNELS     = 4;

	localparam int CH_FIELD_W = 2;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 14;
	localparam int DRAIN_W    = 24;
	localparam int TTE_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_DRAIN_WARN_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LEVEL       = 2'd1;

	localparam logic [DRAIN_W-1:0] RST_WARN_THRESHOLD = 24'd150;
	localparam logic [LEVEL_W-1:0] RST_CRITICAL_LEVEL = 14'd2000;

	// ms to s scaling of the drain, and s to tenths for the time estimates
	localparam logic [DRAIN_W-1:0] DRAIN_SCALE = 24'd1000;
	localparam logic [DRAIN_W-1:0] TENTHS_SCALE = 24'd10;
	localparam logic [TTE_W-1:0]   TIME_MAX = 17'd131071;

	// divider operand widths: numerator never exceeds 16383 * 1000
	localparam int DIV_NUM_W = DRAIN_W;
	localparam int DIV_DEN_W = TIME_W;

	typedef enum logic [1:0] {
		DIV_DRAIN,
		DIV_CRIT,
		DIV_EMPTY
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     push;
		logic     div_start;
		div_sel_t div_sel;
		logic     drain_clear;
		logic     drain_store;
		logic     times_clear;
		logic     tcrit_store;
		logic     tempty_store;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_range;
		logic calc;
		logic level_rise;
		logic drain_zero;
		logic above_crit;
		logic div_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

FILE: src/battery_drain_rate_monitor_unit.sv
// Battery drain rate monitor top level: controller, datapath and config port.
// One item at a time. The drain, critical-time and empty-time divisions run in turn
// in the shared radix-2 divider, and each is skipped when it is not needed.
// A result may wait in the output register while the next item is taken.
// Async reset clears channel state and loads config defaults; no clearing pass.
module battery_drain_rate_monitor_unit import bdrm_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int CHANNELS     = DEF_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CH_FIELD_W-1:0] channel,
	input  logic [TIME_W-1:0]     sample_time_ms,
	input  logic                  level_present,
	input  logic [LEVEL_W-1:0]    battery_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CH_FIELD_W-1:0] out_channel,
	output logic [DRAIN_W-1:0]    discharge_rate,
	output logic                  drain_warning,
	output logic [TTE_W-1:0]      time_to_crit,
	output logic [TTE_W-1:0]      time_to_empty
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// user must write registers only while idle; not enforced here, writes always taken
	assign cfg_ready = 1'b1;

	bdrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdrm_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.CHANNELS     (CHANNELS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.channel          (channel),
		.sample_time_ms   (sample_time_ms),
		.level_present    (level_present),
		.battery_level    (battery_level),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_channel      (out_channel),
		.discharge_rate   (discharge_rate),
		.drain_warning    (drain_warning),
		.time_to_crit     (time_to_crit),
		.time_to_empty    (time_to_empty)
	);

endmodule

FILE: src/bdrm_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module bdrm_divider import bdrm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;

	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: src/bdrm_datapath.sv
// Datapath: sample window memory, per-channel state, divider operands and result register.
module bdrm_datapath import bdrm_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int CHANNELS     = DEF_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output ctrl_sts_t             sts,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CH_FIELD_W-1:0] channel,
	input  logic [TIME_W-1:0]     sample_time_ms,
	input  logic                  level_present,
	input  logic [LEVEL_W-1:0]    battery_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CH_FIELD_W-1:0] out_channel,
	output logic [DRAIN_W-1:0]    discharge_rate,
	output logic                  drain_warning,
	output logic [TTE_W-1:0]      time_to_crit,
	output logic [TTE_W-1:0]      time_to_empty
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHX_W  = (CH_W > CH_FIELD_W) ? CH_W : CH_FIELD_W;
	localparam int PTR_W  = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int MEM_D  = CHANNELS * WINDOW_DEPTH;
	localparam int ADDR_W = $clog2(MEM_D);
	localparam int ENT_W  = TIME_W + LEVEL_W;

	function automatic logic [TTE_W-1:0] sat_tenths(input logic [DIV_NUM_W-1:0] q);
		logic [TTE_W-1:0] r;
		r = (q > DIV_NUM_W'(TIME_MAX)) ? TIME_MAX : q[TTE_W-1:0];
		return r;
	endfunction

	// window memory: {time, level} per slot, channel-major
	logic [ENT_W-1:0] win_mem [MEM_D];

	logic [DRAIN_W-1:0] thresh_q;
	logic [LEVEL_W-1:0] crit_q;
	logic [PTR_W-1:0]   head_q   [CHANNELS];
	logic [CNT_W-1:0]   count_q  [CHANNELS];
	logic [LEVEL_W-1:0] latest_q [CHANNELS];
	logic [DRAIN_W-1:0] drain_q  [CHANNELS];

	logic [CH_FIELD_W-1:0] ch_q;
	logic [TIME_W-1:0]     t_q;
	logic                  present_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [LEVEL_W-1:0]    cur_q;
	logic [ENT_W-1:0]      rd_q;
	logic [TTE_W-1:0]      tcrit_q;
	logic [TTE_W-1:0]      tempty_q;

	logic                  out_valid_q;
	logic [CH_FIELD_W-1:0] out_channel_q;
	logic [DRAIN_W-1:0]    discharge_rate_q;
	logic                  drain_warning_q;
	logic [TTE_W-1:0]      time_to_crit_q;
	logic [TTE_W-1:0]      time_to_empty_q;

	logic [CHX_W-1:0]     ch_ext;
	logic [CH_W-1:0]      ch_idx;
	logic                 in_range;
	logic [PTR_W-1:0]     head;
	logic [CNT_W-1:0]     count;
	logic                 full;
	logic [SUM_W-1:0]     tail_sum;
	logic [PTR_W-1:0]     tail;
	logic [PTR_W-1:0]     head_nx;
	logic [PTR_W-1:0]     wr_slot;
	logic [PTR_W-1:0]     rd_slot;
	logic [ADDR_W-1:0]    base;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr;
	logic [LEVEL_W-1:0]   cur;
	logic [TIME_W-1:0]    t0;
	logic [LEVEL_W-1:0]   l0;
	logic [TIME_W-1:0]    elapsed;
	logic [DRAIN_W-1:0]   drain_cur;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quot;

	always_comb begin
		ch_ext    = CHX_W'(ch_q);
		ch_idx    = ch_ext[CH_W-1:0];
		in_range  = 5'(ch_q) < 5'(CHANNELS);
		head      = head_q[ch_idx];
		count     = count_q[ch_idx];
		full      = count == CNT_W'(WINDOW_DEPTH);
		tail_sum  = SUM_W'(head) + SUM_W'(count);
		tail      = (tail_sum >= SUM_W'(WINDOW_DEPTH)) ?
			PTR_W'(tail_sum - SUM_W'(WINDOW_DEPTH)) : PTR_W'(tail_sum);
		head_nx   = (head == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head + PTR_W'(1);
		// a full ring overwrites its oldest slot, so the oldest moves on by one
		wr_slot   = full ? head : tail;
		rd_slot   = full ? head_nx : head;
		base      = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_DEPTH);
		wr_addr   = base + ADDR_W'(wr_slot);
		rd_addr   = base + ADDR_W'(rd_slot);
		cur       = present_q ? level_q : latest_q[ch_idx];
		t0        = rd_q[ENT_W-1:LEVEL_W];
		l0        = rd_q[LEVEL_W-1:0];
		elapsed   = (t_q > t0) ? (t_q - t0) : TIME_W'(1);
		drain_cur = drain_q[ch_idx];
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_DRAIN: begin
				div_num = DIV_NUM_W'(l0 - cur_q) * DRAIN_SCALE;
				div_den = elapsed;
			end
			DIV_CRIT: begin
				div_num = DIV_NUM_W'(cur_q - crit_q) * TENTHS_SCALE;
				div_den = DIV_DEN_W'(drain_cur);
			end
			DIV_EMPTY: begin
				div_num = DIV_NUM_W'(cur_q) * TENTHS_SCALE;
				div_den = DIV_DEN_W'(drain_cur);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	bdrm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		sts.in_range   = in_range;
		sts.calc       = count != '0;
		sts.level_rise = l0 <= cur_q;
		sts.drain_zero = drain_cur == '0;
		sts.above_crit = cur_q > crit_q;
		sts.div_done   = div_done;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= RST_WARN_THRESHOLD;
			crit_q      <= RST_CRITICAL_LEVEL;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				head_q[i]   <= '0;
				count_q[i]  <= '0;
				latest_q[i] <= '0;
				drain_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DRAIN_WARN_THRESHOLD: thresh_q <= cfg_data[DRAIN_W-1:0];
					REG_CRITICAL_LEVEL:       crit_q   <= cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.push) begin
				latest_q[ch_idx] <= cur;
				if (full) begin
					head_q[ch_idx] <= head_nx;
				end else begin
					count_q[ch_idx] <= count + CNT_W'(1);
				end
			end
			if (cmd.drain_clear) begin
				drain_q[ch_idx] <= '0;
			end else if (cmd.drain_store) begin
				drain_q[ch_idx] <= div_quot[DRAIN_W-1:0];
			end
			// drop the beat once taken, then refill from the finished item
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q      <= channel;
			t_q       <= sample_time_ms;
			present_q <= level_present;
			level_q   <= battery_level;
		end
		if (cmd.push) begin
			cur_q            <= cur;
			win_mem[wr_addr] <= {t_q, cur};
			rd_q             <= win_mem[rd_addr];
		end
		if (cmd.times_clear) begin
			tcrit_q  <= '0;
			tempty_q <= '0;
		end
		if (cmd.tcrit_store) begin
			tcrit_q <= sat_tenths(div_quot);
		end
		if (cmd.tempty_store) begin
			tempty_q <= sat_tenths(div_quot);
		end
		if (cmd.out_load) begin
			out_channel_q <= ch_q;
			if (in_range) begin
				discharge_rate_q <= drain_cur;
				drain_warning_q  <= drain_cur > thresh_q;
				time_to_crit_q   <= tcrit_q;
				time_to_empty_q  <= tempty_q;
			end else begin
				discharge_rate_q <= '0;
				drain_warning_q  <= 1'b0;
				time_to_crit_q   <= '0;
				time_to_empty_q  <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_channel    = out_channel_q;
	assign discharge_rate = discharge_rate_q;
	assign drain_warning  = drain_warning_q;
	assign time_to_crit   = time_to_crit_q;
	assign time_to_empty  = time_to_empty_q;

endmodule

FILE: src/bdrm_ctrl.sv
// Controller: sequences window update, drain division and the two time divisions.
module bdrm_ctrl import bdrm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_PREP,
		S_DDRAIN,
		S_TCRIT,
		S_DCRIT,
		S_TEMPTY,
		S_DEMPTY,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_stall_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PUSH;
				end
			end
			S_PUSH: begin
				if (!sts.in_range) begin
					state_d = S_RESULT;
				end else begin
					cmd.push = 1'b1;
					state_d  = sts.calc ? S_PREP : S_TCRIT;
				end
			end
			S_PREP: begin
				if (sts.level_rise) begin
					cmd.drain_clear = 1'b1;
					state_d         = S_TCRIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_DRAIN;
					state_d       = S_DDRAIN;
				end
			end
			S_DDRAIN: begin
				if (sts.div_done) begin
					cmd.drain_store = 1'b1;
					state_d         = S_TCRIT;
				end
			end
			S_TCRIT: begin
				cmd.times_clear = 1'b1;
				if (!sts.drain_zero && sts.above_crit) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_CRIT;
					state_d       = S_DCRIT;
				end else begin
					state_d = S_TEMPTY;
				end
			end
			S_DCRIT: begin
				if (sts.div_done) begin
					cmd.tcrit_store = 1'b1;
					state_d         = S_TEMPTY;
				end
			end
			S_TEMPTY: begin
				if (!sts.drain_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_EMPTY;
					state_d       = S_DEMPTY;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_DEMPTY: begin
				if (sts.div_done) begin
					cmd.tempty_store = 1'b1;
					state_d          = S_RESULT;
				end
			end
			S_RESULT: begin
				// hold until the output register can take the beat
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_stall_q <= state_d != S_IDLE;
		end
	end

	assign in_stall = in_stall_q;

endmodule

FILE: src/bdrm_checker.sv
// Port-level checker for the drain rate monitor, bound to the top level.
`include "assert_macros.svh"

module bdrm_checker import bdrm_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [CH_FIELD_W-1:0] out_channel,
	input logic [DRAIN_W-1:0]    discharge_rate,
	input logic                  drain_warning,
	input logic [TTE_W-1:0]      time_to_crit,
	input logic [TTE_W-1:0]      time_to_empty
);

	`BDRM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	`BDRM_ASSERT_NOW(a_idle_channel_zero, clk, arst_n, out_valid && (5'(out_channel) >= 5'(CHANNELS)), discharge_rate == '0 && !drain_warning && time_to_crit == '0 && time_to_empty == '0)

	`BDRM_ASSERT_NOW(a_no_drain_no_time, clk, arst_n, out_valid && discharge_rate == '0, time_to_crit == '0 && time_to_empty == '0 && !drain_warning)

	`BDRM_ASSERT_NOW(a_crit_before_empty, clk, arst_n, out_valid, time_to_crit <= time_to_empty)

	`BDRM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(discharge_rate) && $stable(out_channel) && $stable(time_to_empty))

endmodule

bind battery_drain_rate_monitor_unit bdrm_checker #(.CHANNELS(CHANNELS)) u_bdrm_checker (.*);
